FILE: sv/generational_stack_allocator_defines.svh
`ifndef GENERATIONAL_STACK_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_STACK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GSA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GSA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

FILE: sv/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_OFFSET_BITS = 24;
   localparam int DEF_GEN_BITS    = 16;
   localparam int OWNER_BITS      = 16;
   localparam int FUNC_BITS       = 2;
   localparam int SLOT_BITS       = 2;
   localparam int STATUS_BITS     = 2;
   localparam int CSR_IDX_BITS    = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_PUSH       = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_INVALIDATE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_QUERY      = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR      = 2'd3;

   localparam logic [SLOT_BITS-1:0] SLOT_VERTEX = 2'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_INDEX  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TABLE_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_REGION_FULL = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INDEX_CAPACITY  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OWNER_ID        = 2'd2;

endpackage

`default_nettype wire

FILE: sv/gsa_table.sv
`default_nettype none

module gsa_table
   import gsa_pkg::*;
#(
   parameter int DEPTH  = DEF_TABLE_DEPTH,
   parameter int WIDTH  = 4 * DEF_OFFSET_BITS + 2,
   parameter int ADDR_W = $clog2(DEF_TABLE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/gsa_ctrl.sv
`default_nettype none

module gsa_ctrl
   import gsa_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int GEN_BITS    = DEF_GEN_BITS,
   localparam int ID_W       = $clog2(TABLE_DEPTH),
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
   localparam int E_W        = 4 * OFFSET_BITS + 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [FUNC_BITS-1:0]   req_func,
   input  wire logic [SLOT_BITS-1:0]   req_slot,
   input  wire logic [ID_W-1:0]        req_handle_id,
   input  wire logic [GEN_BITS-1:0]    req_handle_generation,
   input  wire logic [OFFSET_BITS-1:0] req_vertex_size,
   input  wire logic [OFFSET_BITS-1:0] req_index_size,
   input  wire logic [OFFSET_BITS-1:0] vertex_capacity,
   input  wire logic [OFFSET_BITS-1:0] index_capacity,
   input  wire logic [OWNER_BITS-1:0]  owner_id,
   output logic                        mem_rd_en,
   output logic      [ID_W-1:0]        mem_rd_addr,
   input  wire logic [E_W-1:0]         mem_rd_data,
   output logic                        mem_wr_en,
   output logic      [ID_W-1:0]        mem_wr_addr,
   output logic      [E_W-1:0]         mem_wr_data,
   output logic                        rsp_valid,
   output logic      [STATUS_BITS-1:0] rsp_status,
   output logic      [ID_W-1:0]        rsp_entry_id,
   output logic      [GEN_BITS-1:0]    rsp_entry_generation,
   output logic      [OWNER_BITS-1:0]  rsp_stack_owner,
   output logic      [OFFSET_BITS-1:0] rsp_vertex_offset,
   output logic      [OFFSET_BITS-1:0] rsp_vertex_length,
   output logic      [OFFSET_BITS-1:0] rsp_index_offset,
   output logic      [OFFSET_BITS-1:0] rsp_index_length
);

   localparam int OB = OFFSET_BITS;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CHECK   = 2'd1;
   localparam logic [1:0] ST_POP_RD  = 2'd2;
   localparam logic [1:0] ST_POP_CHK = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [OB-1:0]          vcur_ff, vcur_in;
   logic [OB-1:0]          icur_ff, icur_in;
   logic [GEN_BITS-1:0]    gen_ff, gen_in;
   logic [FUNC_BITS-1:0]   func_ff, func_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [ID_W-1:0]        hid_ff, hid_in;
   logic [GEN_BITS-1:0]    hgen_ff, hgen_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [GEN_BITS-1:0]    rsp_gen_ff, rsp_gen_in;
   logic [OWNER_BITS-1:0]  rsp_owner_ff, rsp_owner_in;
   logic [OB-1:0]          rsp_vo_ff, rsp_vo_in;
   logic [OB-1:0]          rsp_vl_ff, rsp_vl_in;
   logic [OB-1:0]          rsp_io_ff, rsp_io_in;
   logic [OB-1:0]          rsp_il_ff, rsp_il_in;

   logic [OB-1:0]          e_vo, e_vl, e_io, e_il;
   logic                   e_va, e_ia;
   logic [OB:0]            push_vend, push_iend, e_vend, e_iend;
   logic [CNT_W-1:0]       count_dec, hid_ext;
   logic                   table_full, region_full;
   logic                   slot_is_v, slot_is_i, handle_ok;
   logic                   new_va, new_ia;

   assign e_vo = mem_rd_data[4*OB+1:3*OB+2];
   assign e_vl = mem_rd_data[3*OB+1:2*OB+2];
   assign e_io = mem_rd_data[2*OB+1:OB+2];
   assign e_il = mem_rd_data[OB+1:2];
   assign e_va = mem_rd_data[1];
   assign e_ia = mem_rd_data[0];

   assign push_vend   = {1'b0, vcur_ff} + {1'b0, req_vertex_size};
   assign push_iend   = {1'b0, icur_ff} + {1'b0, req_index_size};
   assign e_vend      = {1'b0, e_vo} + {1'b0, e_vl};
   assign e_iend      = {1'b0, e_io} + {1'b0, e_il};
   assign count_dec   = count_ff - CNT_W'(1);
   assign hid_ext     = CNT_W'(hid_ff);
   assign table_full  = (count_ff == CNT_W'(TABLE_DEPTH));
   assign region_full = (push_vend > {1'b0, vertex_capacity}) ||
                        (push_iend > {1'b0, index_capacity});

   assign slot_is_v = (slot_ff == SLOT_VERTEX);
   assign slot_is_i = (slot_ff == SLOT_INDEX);
   assign handle_ok = (slot_is_v || slot_is_i) && (hid_ext < count_ff) &&
                      (hgen_ff == gen_ff) &&
                      (slot_is_v ? (e_va && (e_vend <= {1'b0, vcur_ff}))
                                 : (e_ia && (e_iend <= {1'b0, icur_ff})));
   assign new_va = e_va && !slot_is_v;
   assign new_ia = e_ia && !slot_is_i;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      vcur_in       = vcur_ff;
      icur_in       = icur_ff;
      gen_in        = gen_ff;
      func_in       = func_ff;
      slot_in       = slot_ff;
      hid_in        = hid_ff;
      hgen_in       = hgen_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_id_in     = hid_ff;
      rsp_gen_in    = gen_ff;
      rsp_owner_in  = owner_id;
      rsp_vo_in     = '0;
      rsp_vl_in     = '0;
      rsp_io_in     = '0;
      rsp_il_in     = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = req_handle_id;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = hid_ff;
      mem_wr_data   = {e_vo, e_vl, e_io, e_il, new_va, new_ia};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               slot_in = req_slot;
               hid_in  = req_handle_id;
               hgen_in = req_handle_generation;
               case (req_func)
                  FUNC_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     if (table_full) begin
                        rsp_status_in = STATUS_TABLE_FULL;
                     end else if (region_full) begin
                        rsp_status_in = STATUS_REGION_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[ID_W-1:0];
                        mem_wr_data = {vcur_ff, req_vertex_size, icur_ff, req_index_size,
                                       1'b1, 1'b1};
                        count_in    = count_ff + CNT_W'(1);
                        vcur_in     = push_vend[OB-1:0];
                        icur_in     = push_iend[OB-1:0];
                        rsp_id_in   = count_ff[ID_W-1:0];
                        rsp_vo_in   = vcur_ff;
                        rsp_vl_in   = req_vertex_size;
                        rsp_io_in   = icur_ff;
                        rsp_il_in   = req_index_size;
                     end
                  end
                  FUNC_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     count_in     = '0;
                     vcur_in      = '0;
                     icur_in      = '0;
                     gen_in       = gen_ff + GEN_BITS'(1);
                     rsp_gen_in   = gen_ff + GEN_BITS'(1);
                  end
                  default: begin
                     mem_rd_en = 1'b1;
                     state_in  = ST_CHECK;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (!handle_ok) begin
               rsp_status_in = STATUS_INVALID;
            end else if (func_ff == FUNC_QUERY) begin
               if (slot_is_v) begin
                  rsp_vo_in = e_vo;
                  rsp_vl_in = e_vl;
               end else begin
                  rsp_io_in = e_io;
                  rsp_il_in = e_il;
               end
            end else begin
               mem_wr_en = 1'b1;
               if ((hid_ext + CNT_W'(1) == count_ff) && !new_va && !new_ia) begin
                  vcur_in      = e_vo;
                  icur_in      = e_io;
                  count_in     = hid_ext;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_POP_RD;
               end
            end
         end
         ST_POP_RD: begin
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = count_dec[ID_W-1:0];
               state_in    = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            if (!e_va && !e_ia) begin
               vcur_in  = e_vo;
               icur_in  = e_io;
               count_in = count_dec;
               state_in = ST_POP_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         vcur_ff      <= '0;
         icur_ff      <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vcur_ff      <= vcur_in;
         icur_ff      <= icur_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      slot_ff       <= slot_in;
      hid_ff        <= hid_in;
      hgen_ff       <= hgen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_vo_ff     <= rsp_vo_in;
      rsp_vl_ff     <= rsp_vl_in;
      rsp_io_ff     <= rsp_io_in;
      rsp_il_ff     <= rsp_il_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_id         = rsp_id_ff;
   assign rsp_entry_generation = rsp_gen_ff;
   assign rsp_stack_owner      = rsp_owner_ff;
   assign rsp_vertex_offset    = rsp_vo_ff;
   assign rsp_vertex_length    = rsp_vl_ff;
   assign rsp_index_offset     = rsp_io_ff;
   assign rsp_index_length     = rsp_il_ff;

endmodule

`default_nettype wire

FILE: sv/generational_stack_allocator.sv
// Channel    Handshake                  Ports
// request    start high, busy low       req_func .. req_index_size
// response   rsp_valid, one cycle       rsp_status .. rsp_index_length
// csr write  csr_valid and csr_ready    csr_index, csr_wdata
//
// Push and clear are served from idle; the response word follows in the next cycle.
// Query and an invalidate that pops nothing answer after a table read and a check.
// An invalidate that pops then reads and checks each lower entry in turn, popping
// those with both ranges invalid; an empty table ends the walk without a read.
// Reset is synchronous; the table contents are not cleared.
// The response cannot be stalled; csr_ready is always high.
`default_nettype none

`include "generational_stack_allocator_defines.svh"

module generational_stack_allocator
   import gsa_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS,
   parameter int GEN_BITS    = DEF_GEN_BITS,
   localparam int ID_W       = $clog2(TABLE_DEPTH),
   localparam int CSR_W      = (OFFSET_BITS > OWNER_BITS) ? OFFSET_BITS : OWNER_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [FUNC_BITS-1:0]    req_func,
   input  wire logic [SLOT_BITS-1:0]    req_slot,
   input  wire logic [ID_W-1:0]         req_handle_id,
   input  wire logic [GEN_BITS-1:0]     req_handle_generation,
   input  wire logic [OFFSET_BITS-1:0]  req_vertex_size,
   input  wire logic [OFFSET_BITS-1:0]  req_index_size,
   output logic                         rsp_valid,
   output logic      [STATUS_BITS-1:0]  rsp_status,
   output logic      [ID_W-1:0]         rsp_entry_id,
   output logic      [GEN_BITS-1:0]     rsp_entry_generation,
   output logic      [OWNER_BITS-1:0]   rsp_stack_owner,
   output logic      [OFFSET_BITS-1:0]  rsp_vertex_offset,
   output logic      [OFFSET_BITS-1:0]  rsp_vertex_length,
   output logic      [OFFSET_BITS-1:0]  rsp_index_offset,
   output logic      [OFFSET_BITS-1:0]  rsp_index_length,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CSR_W-1:0]        csr_wdata
);

   localparam int E_W = 4 * OFFSET_BITS + 2;

   logic [OFFSET_BITS-1:0] vcap_ff, vcap_in;
   logic [OFFSET_BITS-1:0] icap_ff, icap_in;
   logic [OWNER_BITS-1:0]  owner_ff, owner_in;

   logic                   mem_rd_en, mem_wr_en;
   logic [ID_W-1:0]        mem_rd_addr, mem_wr_addr;
   logic [E_W-1:0]         mem_rd_data, mem_wr_data;

   always_comb begin
      vcap_in  = vcap_ff;
      icap_in  = icap_ff;
      owner_in = owner_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VERTEX_CAPACITY: vcap_in  = csr_wdata[OFFSET_BITS-1:0];
            CSR_INDEX_CAPACITY:  icap_in  = csr_wdata[OFFSET_BITS-1:0];
            CSR_OWNER_ID:        owner_in = csr_wdata[OWNER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcap_ff  <= '1;
         icap_ff  <= '1;
         owner_ff <= '0;
      end else begin
         vcap_ff  <= vcap_in;
         icap_ff  <= icap_in;
         owner_ff <= owner_in;
      end
   end

   assign csr_ready = 1'b1;

   gsa_table #(
      .DEPTH  (TABLE_DEPTH),
      .WIDTH  (E_W),
      .ADDR_W (ID_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   gsa_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .OFFSET_BITS (OFFSET_BITS),
      .GEN_BITS    (GEN_BITS)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_slot              (req_slot),
      .req_handle_id         (req_handle_id),
      .req_handle_generation (req_handle_generation),
      .req_vertex_size       (req_vertex_size),
      .req_index_size        (req_index_size),
      .vertex_capacity       (vcap_ff),
      .index_capacity        (icap_ff),
      .owner_id              (owner_ff),
      .mem_rd_en             (mem_rd_en),
      .mem_rd_addr           (mem_rd_addr),
      .mem_rd_data           (mem_rd_data),
      .mem_wr_en             (mem_wr_en),
      .mem_wr_addr           (mem_wr_addr),
      .mem_wr_data           (mem_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_entry_id          (rsp_entry_id),
      .rsp_entry_generation  (rsp_entry_generation),
      .rsp_stack_owner       (rsp_stack_owner),
      .rsp_vertex_offset     (rsp_vertex_offset),
      .rsp_vertex_length     (rsp_vertex_length),
      .rsp_index_offset      (rsp_index_offset),
      .rsp_index_length      (rsp_index_length)
   );

   // A push always answers in the following cycle and leaves the block idle.
   `GSA_ASSERT_NEXT(a_push_answers, start && !busy && req_func == FUNC_PUSH, rsp_valid && !busy)

   // A clear always succeeds with entry zero.
   `GSA_ASSERT_NEXT(a_clear_ok, start && !busy && req_func == FUNC_CLEAR,
      rsp_valid && rsp_status == STATUS_OK && rsp_entry_id == '0)

   // A rejected word carries no ranges.
   `GSA_ASSERT_IMP(a_reject_empty, rsp_valid && rsp_status != STATUS_OK,
      rsp_vertex_offset == '0 && rsp_vertex_length == '0 &&
      rsp_index_offset == '0 && rsp_index_length == '0)

   // Table reads never start a response in the same cycle, so a read request
   // moves the block out of idle.
   `GSA_ASSERT_NEXT(a_read_busy, start && !busy &&
      (req_func == FUNC_QUERY || req_func == FUNC_INVALIDATE), busy && !rsp_valid)

endmodule

`default_nettype wire
